// ===== rtl/core/vrfh_pkg.sv =====
`default_nettype none
package vrfh_pkg;

    localparam int MAP_AXIS_BITS_DEF = 5;

    localparam int TIME_W  = 32;
    localparam int RECIP_W = 31;
    localparam int MAG_W   = 16;
    localparam int OFF_W   = 9;
    localparam int CELL_W  = 19;
    localparam int OUT_W   = 10;
    localparam int DIST_W  = 16;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [TIME_W-1:0] TIME_MAX     = '1;
    localparam logic [DIST_W-1:0] MAX_DIST_RST = 16'd2560;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_CAST  = 1'b1;

    localparam logic REG_MAX_DIST = 1'b0;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_CHECK,
        ST_READ,
        ST_FINISH
    } vrfh_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } recip_status_t;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/vrfh_ram.sv =====
`default_nettype none
module vrfh_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 32768
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/core/vrfh_recip.sv =====
`default_nettype none
// 2^30 / mag, restoring, one quotient bit per cycle
module vrfh_recip
    import vrfh_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [MAG_W-1:0]   mag,
    output logic      [RECIP_W-1:0] quot,
    output recip_status_t           status
);

    logic [4:0]         cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [MAG_W-1:0]   mag_reg;
    logic [MAG_W-1:0]   rem_reg;
    logic [RECIP_W-1:0] quot_reg;
    logic [MAG_W:0]     trial;
    logic               ge;

    assign trial = {rem_reg, (cnt_reg == 5'(RECIP_W - 1))};
    assign ge    = trial >= {1'b0, mag_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(RECIP_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg <= mag;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? MAG_W'(trial - {1'b0, mag_reg}) : trial[MAG_W-1:0];
            quot_reg <= {quot_reg[RECIP_W-2:0], ge};
        end
    end

    assign quot        = quot_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
`default_nettype wire

// ===== rtl/core/voxel_ray_first_hit.sv =====
// voxel_ray_first_hit: first solid voxel along a ray through a cubic occupancy map.
// Request channel (req_valid / req_stall): kind 0 writes one voxel (cell_x/y/z,
// cell_solid) and gives no result; kind 1 casts a ray from origin (Q8.8) along
// dir (Q2.14). Result channel (res_valid / res_stall): hit and hit_x/y/z, one per cast.
// A write request writes the map in the cycle it is taken. A cast runs the three
// parallel bit-serial reciprocals (31 quotient bits, then a done strobe), then the
// first boundary times, then for each voxel checked a limit check and map address,
// then map read data and step; one more limit check when the distance runs out,
// and then the result is loaded.
// The map is a single synchronous RAM read once per step; that read loop sets the rate.
// After reset the map is swept to empty, all 2^(3*MAP_AXIS_BITS) cells (32768 by
// default), with req_stall high; max_distance can be written over APB meanwhile.
// The result register frees the core: the next request is taken while a result
// waits. A cast that finishes while res_stall holds the earlier result waits.
`default_nettype none
module voxel_ray_first_hit
    import vrfh_pkg::*;
#(
    parameter int MAP_AXIS_BITS = MAP_AXIS_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire logic                kind,
    input  wire logic [4:0]          cell_x,
    input  wire logic [4:0]          cell_y,
    input  wire logic [4:0]          cell_z,
    input  wire logic                cell_solid,
    input  wire logic signed [15:0]  origin_x,
    input  wire logic signed [15:0]  origin_y,
    input  wire logic signed [15:0]  origin_z,
    input  wire logic signed [15:0]  dir_x,
    input  wire logic signed [15:0]  dir_y,
    input  wire logic signed [15:0]  dir_z,
    output logic                     res_valid,
    input  wire logic                res_stall,
    output logic                     hit,
    output logic signed [OUT_W-1:0]  hit_x,
    output logic signed [OUT_W-1:0]  hit_y,
    output logic signed [OUT_W-1:0]  hit_z,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [APB_AW-1:0]   paddr,
    input  wire logic [APB_DW-1:0]   pwdata,
    output logic      [APB_DW-1:0]   prdata,
    output logic                     pready
);

    localparam int AW    = 3 * MAP_AXIS_BITS;
    localparam int DEPTH = 1 << AW;

    vrfh_state_t state_reg, state_next;

    logic [AW-1:0]     clr_reg;
    logic [DIST_W-1:0] max_dist_reg;

    logic signed [CELL_W-1:0] cell_reg [3];
    logic [OFF_W-1:0]         off_reg  [3];
    logic [2:0]               pos_reg;
    logic [2:0]               zero_reg;
    logic [TIME_W-1:0]        nb_reg   [3];
    logic [TIME_W-1:0]        st_reg   [3];
    logic [TIME_W-1:0]        travelled_reg;
    logic                     inrange_reg;

    logic                     res_valid_reg;
    logic                     hit_reg;
    logic [OUT_W-1:0]         hx_reg, hy_reg, hz_reg;

    logic                     req_acc;
    logic                     cast_start;
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic                     ram_wdata;
    logic [AW-1:0]            ram_raddr;
    logic                     ram_rdata;
    logic                     solid;
    logic                     out_free;
    logic                     in_limit;
    logic [1:0]               sel;
    logic                     apb_wr;
    logic                     inrange;
    logic [MAP_AXIS_BITS-1:0] wr_x, wr_y, wr_z;

    logic signed [15:0]       org [3];
    logic signed [15:0]       dir [3];
    logic [MAG_W-1:0]         mag [3];
    logic [RECIP_W-1:0]       quot [3];
    recip_status_t            rstat [3];

    assign org[0] = origin_x;
    assign org[1] = origin_y;
    assign org[2] = origin_z;
    assign dir[0] = dir_x;
    assign dir[1] = dir_y;
    assign dir[2] = dir_z;

    assign wr_x = MAP_AXIS_BITS'(cell_x);
    assign wr_y = MAP_AXIS_BITS'(cell_y);
    assign wr_z = MAP_AXIS_BITS'(cell_z);

    assign req_acc    = req_valid && !req_stall;
    assign cast_start = req_acc && (kind == KIND_CAST);
    assign out_free   = !res_valid_reg || !res_stall;
    assign in_limit   = travelled_reg < {8'd0, max_dist_reg, 8'd0};
    assign solid      = inrange_reg && ram_rdata;
    assign apb_wr     = psel && penable && pwrite && pready;

    assign inrange = (cell_reg[0][CELL_W-1:MAP_AXIS_BITS] == '0)
                  && (cell_reg[1][CELL_W-1:MAP_AXIS_BITS] == '0)
                  && (cell_reg[2][CELL_W-1:MAP_AXIS_BITS] == '0);

    generate
        for (genvar a = 0; a < 3; a++)
        begin : g_lane
            assign mag[a] = dir[a][15] ? MAG_W'(-dir[a]) : dir[a];
            vrfh_recip u_recip (
                .clk    (clk),
                .rst_n  (rst_n),
                .start  (cast_start),
                .mag    (mag[a]),
                .quot   (quot[a]),
                .status (rstat[a])
            );
        end
    endgenerate

    // axis choice: strict min, ties go to the later axis (z over y over x)
    always_comb
    begin
        priority if (nb_reg[0] < nb_reg[1] && nb_reg[0] < nb_reg[2])
            sel = 2'd0;
        else if (nb_reg[1] < nb_reg[2])
            sel = 2'd1;
        else
            sel = 2'd2;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (clr_reg == AW'(DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:   if (cast_start) state_next = ST_DIV;
            ST_DIV:    if (rstat[0].done) state_next = ST_MUL;
            ST_MUL:    state_next = ST_CHECK;
            ST_CHECK:  state_next = in_limit ? ST_READ : ST_FINISH;
            ST_READ:   state_next = solid ? ST_FINISH : ST_CHECK;
            ST_FINISH: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        req_stall = 1'b1;
        ram_we    = 1'b0;
        ram_waddr = clr_reg;
        ram_wdata = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
            end
            ST_IDLE:
            begin
                req_stall = 1'b0;
                ram_we    = req_valid && (kind == KIND_WRITE);
                ram_waddr = {wr_z, wr_y, wr_x};
                ram_wdata = cell_solid;
            end
            default:
            begin
            end
        endcase
    end

    assign ram_raddr = {cell_reg[2][MAP_AXIS_BITS-1:0], cell_reg[1][MAP_AXIS_BITS-1:0],
                        cell_reg[0][MAP_AXIS_BITS-1:0]};

    vrfh_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            max_dist_reg  <= MAX_DIST_RST;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (apb_wr && paddr[2] == REG_MAX_DIST)
            begin
                max_dist_reg <= pwdata[DIST_W-1:0];
            end
            if (state_reg == ST_FINISH && out_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        logic [16:0]          sum;
        logic [OFF_W+RECIP_W-1:0] prod;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cast_start)
                begin
                    for (int a = 0; a < 3; a++)
                    begin
                        sum = {org[a][15], org[a]} + 17'd128;
                        cell_reg[a] <= CELL_W'($signed(sum[16:8]));
                        pos_reg[a]  <= !dir[a][15] && (dir[a] != '0);
                        zero_reg[a] <= dir[a] == '0;
                        off_reg[a]  <= (!dir[a][15] && (dir[a] != '0))
                                     ? OFF_W'(9'd256 - {1'b0, sum[7:0]})
                                     : {1'b0, sum[7:0]};
                    end
                end
            end
            ST_MUL:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    prod = (OFF_W+RECIP_W)'(off_reg[a]) * (OFF_W+RECIP_W)'(quot[a]);
                    nb_reg[a] <= zero_reg[a] ? TIME_MAX
                                             : prod[OFF_W+RECIP_W-1:8];
                    st_reg[a] <= zero_reg[a] ? TIME_MAX : TIME_W'(quot[a]);
                end
                travelled_reg <= '0;
                hit_reg       <= 1'b0;
            end
            ST_CHECK:
            begin
                inrange_reg <= inrange;
            end
            ST_READ:
            begin
                if (solid)
                begin
                    hit_reg <= 1'b1;
                end
                else
                begin
                    cell_reg[sel]  <= pos_reg[sel] ? cell_reg[sel] + CELL_W'(1)
                                                   : cell_reg[sel] - CELL_W'(1);
                    travelled_reg  <= nb_reg[sel];
                    nb_reg[sel]    <= sat_add(nb_reg[sel], st_reg[sel]);
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    hx_reg <= cell_reg[0][OUT_W-1:0];
                    hy_reg <= cell_reg[1][OUT_W-1:0];
                    hz_reg <= cell_reg[2][OUT_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    logic res_hit_reg;
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FINISH && out_free)
        begin
            res_hit_reg <= hit_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign hit       = res_hit_reg;
    assign hit_x     = hx_reg;
    assign hit_y     = hy_reg;
    assign hit_z     = hz_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_MAX_DIST) ? APB_DW'(max_dist_reg) : '0;

    a_lanes_together: assert property (@(posedge clk) disable iff (!rst_n)
        rstat[0].done |-> rstat[1].done && rstat[2].done)
        else $error("reciprocal lanes out of step");

    a_div_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && rstat[0].done) |=> state_reg == ST_MUL)
        else $error("boundary setup skipped");

    a_time_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ && !solid) |=> travelled_reg >= $past(travelled_reg))
        else $error("travelled time went backwards");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_free) |=> res_valid && state_reg == ST_IDLE)
        else $error("result not presented");

endmodule
`default_nettype wire
